// File: src/mtwd_pkg.sv
// Package for the multi-task watchdog monitor: sizes, codes and shared types.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package mtwd_pkg;

  localparam int SLOTS      = 8;
  localparam int ID_WIDTH   = 16;
  localparam int TASK_ID_W  = 16;
  localparam int ID_W       = (ID_WIDTH < TASK_ID_W) ? ID_WIDTH : TASK_ID_W;
  localparam int TIME_W     = 32;
  localparam int COUNT_W    = 8;
  localparam int SLOT_OUT_W = 3;
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int CFG_IDX_W  = 1;

  localparam logic [TIME_W-1:0]  TIMEOUT_RST  = 32'd5000;
  localparam logic [COUNT_W-1:0] ESCALATE_RST = 8'd3;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'hFF;

  typedef enum logic [1:0] {
    REQ_REGISTER = 2'd0,
    REQ_KICK     = 2'd1,
    REQ_CHECK    = 2'd2,
    REQ_NONE     = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    STAT_REGISTERED = 3'd0,
    STAT_FULL       = 3'd1,
    STAT_KICKED     = 3'd2,
    STAT_UNKNOWN    = 3'd3,
    STAT_RECOVER    = 3'd4,
    STAT_SYSRESET   = 3'd5,
    STAT_NONE       = 3'd6
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT  = 1'b0,
    REG_ESCALATE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  kick;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    status_e               status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [TASK_ID_W-1:0]  id;
    logic [COUNT_W-1:0]    count;
  } res_t;

  typedef struct packed {
    logic   hit;
    logic   found;
    res_t   res;
    entry_t entry;
  } head_t;

endpackage

// File: src/mtwd_cell.sv
// One slot cell of the rotating slot chain.
// Depends on mtwd_pkg for the slot entry type.
`timescale 1ns / 1ps

module mtwd_cell (
  input  logic            clk_i,
  input  logic            shift_i,
  input  mtwd_pkg::entry_t entry_i,
  output mtwd_pkg::entry_t entry_o
);

  mtwd_pkg::entry_t entry_q;

  // Slot contents are undefined until written, so the cell has no reset.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;

endmodule

// File: src/mtwd_head.sv
// Slot evaluation unit at the head of the slot chain: decides whether the
// slot now at the head produces a result and what the slot becomes.
// Depends on mtwd_pkg.
`timescale 1ns / 1ps

module mtwd_head (
  input  mtwd_pkg::entry_t                 entry_i,
  input  mtwd_pkg::req_e                   req_i,
  input  logic [mtwd_pkg::ID_W-1:0]        req_id_i,
  input  logic [mtwd_pkg::TIME_W-1:0]      now_i,
  input  logic [mtwd_pkg::CNT_W-1:0]       step_i,
  input  logic [mtwd_pkg::CNT_W-1:0]       used_i,
  input  logic                             found_i,
  input  logic [mtwd_pkg::TIME_W-1:0]      timeout_i,
  input  logic [mtwd_pkg::COUNT_W-1:0]     escalate_i,
  output mtwd_pkg::head_t                  head_o
);

  logic                           in_use;
  logic [mtwd_pkg::TIME_W-1:0]    elapsed;
  logic [mtwd_pkg::COUNT_W-1:0]   count_inc;

  assign in_use    = step_i < used_i;
  assign elapsed   = now_i - entry_i.kick;
  assign count_inc = (entry_i.count == mtwd_pkg::COUNT_MAX) ? entry_i.count
                                                            : entry_i.count + 8'd1;

  always_comb begin
    head_o            = '0;
    head_o.entry      = entry_i;
    head_o.res.slot   = mtwd_pkg::SLOT_OUT_W'(step_i);
    head_o.res.id     = mtwd_pkg::TASK_ID_W'(entry_i.id);
    head_o.res.count  = entry_i.count;
    head_o.res.status = mtwd_pkg::STAT_NONE;
    case (req_i)
      mtwd_pkg::REQ_REGISTER: begin
        if (step_i == used_i) begin
          head_o.hit         = 1'b1;
          head_o.entry.id    = req_id_i;
          head_o.entry.kick  = now_i;
          head_o.entry.count = '0;
          head_o.res.status  = mtwd_pkg::STAT_REGISTERED;
          head_o.res.id      = mtwd_pkg::TASK_ID_W'(req_id_i);
          head_o.res.count   = '0;
        end
      end
      mtwd_pkg::REQ_KICK: begin
        if (in_use && !found_i && (entry_i.id == req_id_i)) begin
          head_o.hit         = 1'b1;
          head_o.found       = 1'b1;
          head_o.entry.kick  = now_i;
          head_o.entry.count = '0;
          head_o.res.status  = mtwd_pkg::STAT_KICKED;
        end
      end
      mtwd_pkg::REQ_CHECK: begin
        if (in_use && (elapsed > timeout_i)) begin
          head_o.hit         = 1'b1;
          head_o.entry.kick  = now_i;
          head_o.entry.count = count_inc;
          head_o.res.status  = (entry_i.count >= escalate_i) ? mtwd_pkg::STAT_SYSRESET
                                                             : mtwd_pkg::STAT_RECOVER;
        end
      end
      default: begin
        head_o.hit = 1'b0;
      end
    endcase
  end

endmodule

// File: src/multi_task_watchdog_monitor.sv
// Top level of the multi-task watchdog monitor: slot chain, head unit,
// sequencer, result holding stages and configuration registers.
// Depends on mtwd_pkg, mtwd_cell and mtwd_head.
`timescale 1ns / 1ps

// The monitor keeps a table of SLOTS tasks (id, last kick time, timeout
// count) in a ring of cells that rotates by one position per step, so each
// slot passes the single evaluation unit once per request. Every request,
// whether register, kick or check, walks all slots: one accepted transaction
// passes through one walk step per slot, a finishing state and an idle state in
// which the next transaction is accepted, and output stall can hold the walk and
// the finish. The walk is set by the one compare path at the head of the ring.
// A register request stores the task in the next free slot or reports a full
// table. A kick request re-arms the first slot with a matching id. A check
// request reports each slot whose elapsed time exceeds the timeout register, as
// a recover or, once its count has reached the escalation register, a system
// reset, then bumps the count and re-arms the slot.
// Results leave through an output register with one more result held behind
// it, so the last flag can be set on the final result of a transaction. The
// next request is accepted while the final result still waits at the output.
// Configuration writes are always taken; they are meant for idle periods.
module multi_task_watchdog_monitor (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           req_type_i,
  input  logic [mtwd_pkg::TASK_ID_W-1:0]       task_id_i,
  input  logic [mtwd_pkg::TIME_W-1:0]          now_ms_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [2:0]                           status_o,
  output logic [mtwd_pkg::SLOT_OUT_W-1:0]      slot_o,
  output logic [mtwd_pkg::TASK_ID_W-1:0]       task_id_out_o,
  output logic [mtwd_pkg::COUNT_W-1:0]         tmo_count_o,
  output logic                                 last_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mtwd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mtwd_pkg::TIME_W-1:0]          cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_WALK   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Control state.
  logic [mtwd_pkg::CNT_W-1:0]   step_q, step_d;
  logic [mtwd_pkg::CNT_W-1:0]   used_q, used_d;
  logic                         found_q, found_d;
  logic                         pend_valid_q, pend_valid_d;
  logic                         out_valid_q, out_valid_d;
  logic [mtwd_pkg::TIME_W-1:0]  timeout_q;
  logic [mtwd_pkg::COUNT_W-1:0] escalate_q;

  // Payload registers of the current transaction and the result stages.
  mtwd_pkg::req_e               req_q;
  logic [mtwd_pkg::ID_W-1:0]    req_id_q;
  logic [mtwd_pkg::TIME_W-1:0]  now_q;
  mtwd_pkg::res_t               pend_q, pend_d;
  mtwd_pkg::res_t               out_q, out_d;
  logic                         out_last_q, out_last_d;

  logic                         in_accept;
  logic                         out_free;
  logic                         out_load;
  logic                         advance;
  logic                         shift;
  mtwd_pkg::res_t               final_res;
  mtwd_pkg::head_t              head;
  mtwd_pkg::entry_t             chain [mtwd_pkg::SLOTS+1];

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // The output register can take a new result when it is empty or its
  // current result is being taken in this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  // A hit with a result already held must first move that result on.
  assign advance = !(head.hit && pend_valid_q) || out_free;
  assign shift   = (state_q == ST_WALK) && advance;

  // Ring of slot cells: each cell hands its slot to the lower neighbor, and
  // the head unit's updated slot enters at the top.
  for (genvar g = 0; g < mtwd_pkg::SLOTS; g++) begin : g_cell
    mtwd_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .entry_i (chain[g+1]),
      .entry_o (chain[g])
    );
  end
  assign chain[mtwd_pkg::SLOTS] = head.entry;

  mtwd_head u_head (
    .entry_i    (chain[0]),
    .req_i      (req_q),
    .req_id_i   (req_id_q),
    .now_i      (now_q),
    .step_i     (step_q),
    .used_i     (used_q),
    .found_i    (found_q),
    .timeout_i  (timeout_q),
    .escalate_i (escalate_q),
    .head_o     (head)
  );

  // Result given at the end of a transaction when the walk held none.
  always_comb begin
    final_res = '0;
    case (req_q)
      mtwd_pkg::REQ_REGISTER: begin
        final_res.status = mtwd_pkg::STAT_FULL;
        final_res.id     = mtwd_pkg::TASK_ID_W'(req_id_q);
      end
      mtwd_pkg::REQ_KICK: begin
        final_res.status = mtwd_pkg::STAT_UNKNOWN;
        final_res.id     = mtwd_pkg::TASK_ID_W'(req_id_q);
      end
      default: begin
        final_res.status = mtwd_pkg::STAT_NONE;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    used_d       = used_q;
    found_d      = found_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_load     = 1'b0;
    out_d        = out_q;
    out_last_d   = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_WALK;
          step_d  = '0;
          found_d = 1'b0;
        end
      end
      ST_WALK: begin
        if (advance) begin
          if (head.hit) begin
            if (pend_valid_q) begin
              out_load   = 1'b1;
              out_d      = pend_q;
              out_last_d = 1'b0;
            end
            pend_d       = head.res;
            pend_valid_d = 1'b1;
            found_d      = found_q || head.found;
          end
          step_d = step_q + 1'b1;
          if (step_q == mtwd_pkg::CNT_W'(mtwd_pkg::SLOTS - 1)) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (req_q == mtwd_pkg::REQ_NONE) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_d        = pend_valid_q ? pend_q : final_res;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          if ((req_q == mtwd_pkg::REQ_REGISTER) &&
              (used_q < mtwd_pkg::CNT_W'(mtwd_pkg::SLOTS))) begin
            used_d = used_q + 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= '0;
      used_q       <= '0;
      found_q      <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      timeout_q    <= mtwd_pkg::TIMEOUT_RST;
      escalate_q   <= mtwd_pkg::ESCALATE_RST;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      used_q       <= used_d;
      found_q      <= found_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (mtwd_pkg::cfg_reg_e'(cfg_index_i))
          mtwd_pkg::REG_TIMEOUT:  timeout_q  <= cfg_data_i;
          mtwd_pkg::REG_ESCALATE: escalate_q <= cfg_data_i[mtwd_pkg::COUNT_W-1:0];
          default:                timeout_q  <= timeout_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q    <= mtwd_pkg::req_e'(req_type_i);
      req_id_q <= task_id_i[mtwd_pkg::ID_W-1:0];
      now_q    <= now_ms_i;
    end
    pend_q <= pend_d;
    if (out_load) begin
      out_q      <= out_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign slot_o          = out_q.slot;
  assign task_id_out_o   = out_q.id;
  assign tmo_count_o     = out_q.count;
  assign last_o          = out_last_q;

  // Between transactions no result may be left behind the output register.
  a_idle_no_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_valid_q)
    else $error("result still held while idle");

  // The fill count never passes the table size.
  a_used_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= mtwd_pkg::CNT_W'(mtwd_pkg::SLOTS))
    else $error("slot fill count out of range");

  // A finishing transaction that gives results closes with a final result.
  a_finish_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FINISH) && (req_q != mtwd_pkg::REQ_NONE) && out_free)
      |=> (out_valid_o && last_o))
    else $error("transaction finished without a final result");

  // The walk never runs past the last slot.
  a_walk_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (step_q < mtwd_pkg::CNT_W'(mtwd_pkg::SLOTS)))
    else $error("walk step out of range");

endmodule

// File: verif/mtwd_result_checker.sv
// Result checker for the multi-task watchdog monitor: watches the request, result and
// configuration channels, predicts every result and compares it field by field.
// Depends on mtwd_pkg for sizes, request and status codes and register indexes.
`timescale 1ns / 1ps

module mtwd_result_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [1:0]                      req_type_i,
  input  logic [mtwd_pkg::TASK_ID_W-1:0]  task_id_i,
  input  logic [mtwd_pkg::TIME_W-1:0]     now_ms_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [2:0]                      status_i,
  input  logic [mtwd_pkg::SLOT_OUT_W-1:0] slot_i,
  input  logic [mtwd_pkg::TASK_ID_W-1:0]  task_id_out_i,
  input  logic [mtwd_pkg::COUNT_W-1:0]    tmo_count_i,
  input  logic                            last_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [mtwd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mtwd_pkg::TIME_W-1:0]     cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              results_seen_o,
  output int                              peak_count_o
);

  typedef struct packed {
    mtwd_pkg::status_e               status;
    logic [mtwd_pkg::SLOT_OUT_W-1:0] slot;
    logic [mtwd_pkg::TASK_ID_W-1:0]  id;
    logic [mtwd_pkg::COUNT_W-1:0]    count;
    logic                            last;
  } wd_result_t;

  logic [mtwd_pkg::ID_W-1:0]    task_ids    [mtwd_pkg::SLOTS];
  logic [mtwd_pkg::TIME_W-1:0]  kick_times  [mtwd_pkg::SLOTS];
  logic [mtwd_pkg::COUNT_W-1:0] miss_counts [mtwd_pkg::SLOTS];
  int                           used_slots;
  logic [mtwd_pkg::TIME_W-1:0]  tmo_limit;
  logic [mtwd_pkg::COUNT_W-1:0] escalate_after;
  wd_result_t                   awaited_results [$];
  int                           fails        = 0;
  int                           results_seen = 0;
  int                           peak_count   = 0;

  assign fail_count_o   = fails;
  assign results_seen_o = results_seen;
  assign peak_count_o   = peak_count;

  function automatic void await_result(mtwd_pkg::status_e st, int slot,
                                       logic [mtwd_pkg::TASK_ID_W-1:0] id,
                                       logic [mtwd_pkg::COUNT_W-1:0] count, logic last);
    wd_result_t r;
    r.status = st;
    r.slot   = slot[mtwd_pkg::SLOT_OUT_W-1:0];
    r.id     = id;
    r.count  = count;
    r.last   = last;
    awaited_results.push_back(r);
    if (int'(count) > peak_count) peak_count = int'(count);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  // Applies one request to the copy of the task table and queues what it must produce.
  task automatic predict_watchdog(input logic [1:0] req,
                                  input logic [mtwd_pkg::TASK_ID_W-1:0] id_in,
                                  input logic [mtwd_pkg::TIME_W-1:0] now);
    logic [mtwd_pkg::ID_W-1:0]   id;
    logic [mtwd_pkg::TIME_W-1:0] elapsed;
    wd_result_t                  tail;
    int                          found;
    int                          hits;
    id    = id_in[mtwd_pkg::ID_W-1:0];
    found = -1;
    hits  = 0;
    case (mtwd_pkg::req_e'(req))
      mtwd_pkg::REQ_REGISTER: begin
        if (used_slots >= mtwd_pkg::SLOTS) begin
          await_result(mtwd_pkg::STAT_FULL, 0, mtwd_pkg::TASK_ID_W'(id), '0, 1'b1);
        end else begin
          task_ids[used_slots]    = id;
          kick_times[used_slots]  = now;
          miss_counts[used_slots] = '0;
          await_result(mtwd_pkg::STAT_REGISTERED, used_slots, mtwd_pkg::TASK_ID_W'(id),
                       '0, 1'b1);
          used_slots++;
        end
      end
      mtwd_pkg::REQ_KICK: begin
        for (int i = 0; i < used_slots; i++) begin
          if (found < 0 && task_ids[i] == id) found = i;
        end
        if (found < 0) begin
          await_result(mtwd_pkg::STAT_UNKNOWN, 0, mtwd_pkg::TASK_ID_W'(id), '0, 1'b1);
        end else begin
          await_result(mtwd_pkg::STAT_KICKED, found, mtwd_pkg::TASK_ID_W'(id),
                       miss_counts[found], 1'b1);
          kick_times[found]  = now;
          miss_counts[found] = '0;
        end
      end
      mtwd_pkg::REQ_CHECK: begin
        for (int i = 0; i < used_slots; i++) begin
          elapsed = now - kick_times[i];
          if (elapsed > tmo_limit) begin
            await_result((miss_counts[i] >= escalate_after) ? mtwd_pkg::STAT_SYSRESET
                                                            : mtwd_pkg::STAT_RECOVER,
                         i, mtwd_pkg::TASK_ID_W'(task_ids[i]), miss_counts[i], 1'b0);
            if (miss_counts[i] != mtwd_pkg::COUNT_MAX) begin
              miss_counts[i] = miss_counts[i] + 1'b1;
            end
            kick_times[i] = now;
            hits++;
          end
        end
        if (hits == 0) begin
          await_result(mtwd_pkg::STAT_NONE, 0, '0, '0, 1'b1);
        end else begin
          tail      = awaited_results.pop_back();
          tail.last = 1'b1;
          awaited_results.push_back(tail);
        end
      end
      default: begin
        // The spare request code is dropped by the block without any result.
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    wd_result_t want;
    if (!rst_ni) begin
      used_slots     = 0;
      tmo_limit      = mtwd_pkg::TIMEOUT_RST;
      escalate_after = mtwd_pkg::ESCALATE_RST;
      awaited_results.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $error("result with no request awaiting it: status %0d slot %0d id 0x%0h",
                 status_i, slot_i, task_id_out_i);
          fails++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 32'(want.status), 32'(status_i));
          check_field("slot", 32'(want.slot), 32'(slot_i));
          check_field("task_id_out", 32'(want.id), 32'(task_id_out_i));
          check_field("tmo_count", 32'(want.count), 32'(tmo_count_i));
          check_field("last", 32'(want.last), 32'(last_i));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (mtwd_pkg::cfg_reg_e'(cfg_index_i))
          mtwd_pkg::REG_TIMEOUT:  tmo_limit = cfg_data_i;
          mtwd_pkg::REG_ESCALATE: escalate_after = cfg_data_i[mtwd_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_watchdog(req_type_i, task_id_i, now_ms_i);
      pending_o <= awaited_results.size();
    end
  end

endmodule

// File: verif/tb_top.sv
// Top of the watchdog monitor testbench: clock, reset, request and register traffic,
// result-side stalling and the final verdict.
// Depends on mtwd_pkg, multi_task_watchdog_monitor and mtwd_result_checker.
`timescale 1ns / 1ps

module tb_top;

  // A request that produces no result still walks all slots; this drain margin is
  // ample to be sure such a request has left the block.
  localparam int DRAIN_CYCLES = 2 * (mtwd_pkg::SLOTS + 2);
  localparam int HOLD_CYCLES  = 250;

  // Ids registered by the directed part, in slot order. The last slot repeats the
  // id of slot zero, so a kick can never reach it and its count climbs to the limit.
  localparam logic [mtwd_pkg::TASK_ID_W-1:0] TASK_IDS [mtwd_pkg::SLOTS] = '{
    16'h0000, 16'hFFFF, 16'h1234, 16'hFFFF, 16'hABCD, 16'h5A5A, 16'h0001, 16'h0000
  };

  logic                            clk            = 1'b0;
  logic                            rst_n          = 1'b0;
  logic                            in_valid       = 1'b0;
  logic                            in_stall;
  logic [1:0]                      req_type       = mtwd_pkg::REQ_CHECK;
  logic [mtwd_pkg::TASK_ID_W-1:0]  task_id        = '0;
  logic [mtwd_pkg::TIME_W-1:0]     now_ms         = '0;
  logic                            out_valid;
  logic                            out_stall      = 1'b0;
  logic [2:0]                      status;
  logic [mtwd_pkg::SLOT_OUT_W-1:0] slot;
  logic [mtwd_pkg::TASK_ID_W-1:0]  task_id_out;
  logic [mtwd_pkg::COUNT_W-1:0]    tmo_count;
  logic                            last;
  logic                            cfg_valid      = 1'b0;
  logic                            cfg_ready;
  logic [mtwd_pkg::CFG_IDX_W-1:0]  cfg_index      = mtwd_pkg::REG_TIMEOUT;
  logic [mtwd_pkg::TIME_W-1:0]     cfg_data       = '0;

  int                              fail_count;
  int                              pending;
  int                              results_seen;
  int                              peak_count;
  int                              burst_left     = 0;
  int                              requests_sent  = 0;
  int                              settings_run   = 1;
  bit                              hold_req       = 1'b0;
  logic [mtwd_pkg::TIME_W-1:0]     sim_ms;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  multi_task_watchdog_monitor u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .req_type_i      (req_type),
    .task_id_i       (task_id),
    .now_ms_i        (now_ms),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (status),
    .slot_o          (slot),
    .task_id_out_o   (task_id_out),
    .tmo_count_o     (tmo_count),
    .last_o          (last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  mtwd_result_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .req_type_i      (req_type),
    .task_id_i       (task_id),
    .now_ms_i        (now_ms),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .status_i        (status),
    .slot_i          (slot),
    .task_id_out_i   (task_id_out),
    .tmo_count_i     (tmo_count),
    .last_i          (last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .results_seen_o  (results_seen),
    .peak_count_o    (peak_count)
  );

  // Result side. The stall pattern changes after each random stretch between no stall,
  // light, even and heavy stalling. Once the request side asks for it, the receiver
  // holds off for a long stretch so the output stages fill and the block stalls its
  // request channel while new transactions keep being offered.
  initial begin : receiver
    int  mode;
    int  stretch;
    bit  held;
    held = 1'b0;
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode    = $urandom_range(0, 3);
        stretch = $urandom_range(8, 40);
        repeat (stretch) begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Offers one request and returns at the edge where it is taken. Requests go out in
  // bursts; before a new burst the valid may drop for a random gap. Within a burst
  // valid stays high, so it is never lowered and raised in the same step.
  task automatic send_req(input mtwd_pkg::req_e req,
                          input logic [mtwd_pkg::TASK_ID_W-1:0] id,
                          input logic [mtwd_pkg::TIME_W-1:0] at_ms);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    req_type <= req;
    task_id  <= id;
    now_ms   <= at_ms;
    do @(posedge clk); while (in_stall);
    burst_left--;
    requests_sent++;
  endtask

  // Stops offering requests and waits until every awaited result has come back,
  // then lets the block finish any walk that yields no result.
  task automatic settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes both registers back to back with the write valid held high between them.
  task automatic write_config(input logic [mtwd_pkg::TIME_W-1:0] tmo,
                              input logic [mtwd_pkg::COUNT_W-1:0] esc);
    cfg_valid <= 1'b1;
    cfg_index <= mtwd_pkg::REG_TIMEOUT;
    cfg_data  <= tmo;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= mtwd_pkg::REG_ESCALATE;
    cfg_data  <= mtwd_pkg::TIME_W'(esc);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  // One random phase under one register setting. With a narrow clock the time steps
  // are scaled to the timeout, so some slots time out and others do not; with a wide
  // clock every time value is random. Most non-check requests kick a registered task.
  task automatic run_phase(input logic [mtwd_pkg::TIME_W-1:0] tmo,
                           input logic [mtwd_pkg::COUNT_W-1:0] esc,
                           input int count, input int check_pct, input bit wide_clock,
                           input bit with_hold);
    int                          roll;
    logic [mtwd_pkg::TIME_W-1:0] span;
    logic [mtwd_pkg::TIME_W-1:0] at_ms;
    settle();
    write_config(tmo, esc);
    if (with_hold) hold_req = 1'b1;
    span = (tmo < 1000) ? 2 * tmo + 1 : 2000;
    repeat (count) begin
      if (wide_clock) begin
        at_ms = $urandom();
      end else begin
        sim_ms = sim_ms + $urandom_range(0, span);
        at_ms  = sim_ms;
      end
      roll = $urandom_range(0, 99);
      if (roll < check_pct) begin
        send_req(mtwd_pkg::REQ_CHECK, mtwd_pkg::TASK_ID_W'($urandom()), at_ms);
      end else begin
        case ($urandom_range(0, 9))
          7:       send_req(mtwd_pkg::REQ_REGISTER, mtwd_pkg::TASK_ID_W'($urandom()), at_ms);
          8:       send_req(mtwd_pkg::REQ_NONE, mtwd_pkg::TASK_ID_W'($urandom()), at_ms);
          9:       send_req(mtwd_pkg::REQ_KICK, mtwd_pkg::TASK_ID_W'($urandom()), at_ms);
          default: send_req(mtwd_pkg::REQ_KICK,
                            TASK_IDS[$urandom_range(0, mtwd_pkg::SLOTS - 1)], at_ms);
        endcase
      end
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n  <= 1'b1;
    sim_ms = $urandom();

    // Directed part at the reset setting (timeout 5000 ms, escalation at 3).
    // An empty table gives no timeout on a check and an unknown task on a kick,
    // and the spare request code is ignored.
    send_req(mtwd_pkg::REQ_CHECK, 16'h0000, 32'd100);
    send_req(mtwd_pkg::REQ_KICK, 16'h1234, 32'd100);
    send_req(mtwd_pkg::REQ_NONE, 16'hFFFF, 32'hFFFF_FFFF);
    // Four tasks, one id twice; the first one is armed just before the clock wraps.
    send_req(mtwd_pkg::REQ_REGISTER, TASK_IDS[0], 32'hFFFF_FF00);
    send_req(mtwd_pkg::REQ_REGISTER, TASK_IDS[1], 32'h0000_0000);
    send_req(mtwd_pkg::REQ_REGISTER, TASK_IDS[2], 32'h0000_0000);
    send_req(mtwd_pkg::REQ_REGISTER, TASK_IDS[3], 32'd1000);
    // The kick of the repeated id must land on its first slot only.
    send_req(mtwd_pkg::REQ_KICK, 16'hFFFF, 32'h100);
    // Elapsed time across the wrap: small for slot zero, huge for the slot armed at 1000.
    send_req(mtwd_pkg::REQ_CHECK, 16'h0000, 32'h100);
    // Exactly the timeout is not a timeout; one millisecond more is.
    send_req(mtwd_pkg::REQ_CHECK, 16'h0000, 32'h100 + 32'd5000);
    send_req(mtwd_pkg::REQ_CHECK, 16'h0000, 32'h100 + 32'd5001);
    // Repeated timeouts drive counts up to the escalation level and past it.
    send_req(mtwd_pkg::REQ_CHECK, 16'h0000, 32'd20000);
    send_req(mtwd_pkg::REQ_CHECK, 16'h0000, 32'd40000);
    send_req(mtwd_pkg::REQ_CHECK, 16'h0000, 32'd60000);
    // A kick reports the count it clears.
    send_req(mtwd_pkg::REQ_KICK, 16'h1234, 32'd60000);
    for (int i = 4; i < mtwd_pkg::SLOTS; i++) begin
      send_req(mtwd_pkg::REQ_REGISTER, TASK_IDS[i], 32'd60000);
    end
    // Full table, unknown task on a full table, checks at the far ends of the clock.
    send_req(mtwd_pkg::REQ_REGISTER, 16'h7777, 32'd60000);
    send_req(mtwd_pkg::REQ_KICK, 16'h4321, 32'd60000);
    send_req(mtwd_pkg::REQ_CHECK, 16'h0000, 32'h8000_0000);
    send_req(mtwd_pkg::REQ_KICK, 16'h0000, 32'h8000_0000);
    send_req(mtwd_pkg::REQ_CHECK, 16'h0000, 32'hFFFF_FFFF);

    // Random phases: a short timeout with low escalation; a zero timeout with the
    // highest escalation and the long receiver hold-off, which times out every slot
    // on every check until the unkickable slot saturates; the largest timeout, which
    // never fires; escalation at zero; and fully random register values.
    run_phase(mtwd_pkg::TIME_W'($urandom_range(20, 400)),
              mtwd_pkg::COUNT_W'($urandom_range(1, 6)), 30, 45, 1'b0, 1'b0);
    run_phase(32'd0, 8'd255, 250, 100, 1'b1, 1'b1);
    run_phase(32'hFFFF_FFFF, 8'd0, 15, 50, 1'b0, 1'b0);
    run_phase(32'd50, 8'd0, 15, 40, 1'b0, 1'b0);
    run_phase(mtwd_pkg::TIME_W'($urandom()), mtwd_pkg::COUNT_W'($urandom()),
              10, 60, 1'b1, 1'b0);
    settle();

    $display("Run covered %0d requests and %0d results under %0d register settings;",
             requests_sent, results_seen, settings_run);
    $display("the highest timeout count reported was %0d.", peak_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run.
  initial begin : watchdog_limit
    #10_000_000;
    $display("Timeout: %0d results still awaited after %0d requests", pending, requests_sent);
    $display("Regression FAIL");
    $finish;
  end

endmodule
